### rtl/sfcg_pkg.sv
// Shared constants and the command record passed from the frame parser to the reply engine.
package sfcg_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int MAX_DLC_DEF      = 8;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'h55;

  localparam logic [7:0] OP_CAN_TX = 8'h01;
  localparam logic [7:0] OP_MODE   = 8'h20;
  localparam logic [7:0] OP_STATUS = 8'h21;
  localparam logic [7:0] OP_ERROR  = 8'hF0;

  localparam logic [7:0] ERR_LENGTH   = 8'h01;
  localparam logic [7:0] ERR_DLC      = 8'h02;
  localparam logic [7:0] ERR_COMMAND  = 8'h03;
  localparam logic [7:0] ERR_CHECKSUM = 8'h04;

  localparam logic [7:0] MIN_LEN = 8'd5;

  typedef struct packed {
    logic            is_can;
    logic            is_status;
    logic [3:0][7:0] info;
    logic [15:0]     id;
    logic [3:0]      dlc;
    logic [63:0]     data;
  } cmd_t;

endpackage

### rtl/sfcg_front.sv
// Frame parser: hunts for the start byte, collects the frame and classifies the command.
module sfcg_front #(
  parameter int BUFFER_BYTES = 64,
  parameter int MAX_DLC      = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    node_id,
  output logic          push_valid,
  input  logic          push_ready,
  output sfcg_pkg::cmd_t push_cmd
);
  import sfcg_pkg::*;

  localparam int CNT_W   = $clog2(BUFFER_BYTES + 1);
  localparam int DATA_N  = (MAX_DLC > 8) ? 8 : MAX_DLC;
  localparam int WIN     = 4 + DATA_N;
  localparam int IDX_W   = $clog2(WIN);
  localparam logic [8:0] MAX_LEN = 9'(BUFFER_BYTES - 4);
  localparam logic [7:0] DLC_LIM = 8'(MAX_DLC);

  logic [CNT_W-1:0] count;
  logic [7:0]       len;
  logic [7:0]       xacc;
  logic [7:0]       store [WIN];
  logic             pend;
  logic             pend_bad;
  logic [7:0]       mode;
  logic [7:0]       tally;

  logic             accept;
  logic [CNT_W-1:0] offset;
  logic [8:0]       tail_pos;
  logic [7:0]       op;
  logic [7:0]       dlc;
  logic             is_err;
  logic [7:0]       err_code;
  logic             act_can;
  logic             act_mode;
  logic             act_status;
  logic             done;

  assign in_ready = !pend;
  assign accept   = in_valid && in_ready;
  assign offset   = count - CNT_W'(2);
  assign tail_pos = {1'b0, len} + 9'd3;
  assign op       = store[0];
  assign dlc      = store[3];

  always_comb begin
    is_err     = 1'b0;
    err_code   = ERR_COMMAND;
    act_can    = 1'b0;
    act_mode   = 1'b0;
    act_status = 1'b0;
    if (pend_bad) begin
      is_err   = 1'b1;
      err_code = ERR_CHECKSUM;
    end else if (len < MIN_LEN) begin
      is_err   = 1'b1;
      err_code = ERR_LENGTH;
    end else if (dlc > DLC_LIM) begin
      is_err   = 1'b1;
      err_code = ERR_DLC;
    end else if (op == OP_CAN_TX) begin
      act_can = 1'b1;
    end else if (op == OP_MODE) begin
      act_mode = 1'b1;
    end else if (op == OP_STATUS) begin
      act_status = 1'b1;
    end else begin
      is_err = 1'b1;
    end
  end

  always_comb begin
    push_cmd           = '0;
    push_cmd.is_can    = act_can;
    push_cmd.is_status = act_status;
    push_cmd.id        = {store[1], store[2]};
    push_cmd.dlc       = dlc[3:0];
    for (int i = 0; i < DATA_N; i++) begin
      if (8'(i) < dlc) begin
        push_cmd.data[8*i +: 8] = store[4 + i];
      end
    end
    if (act_status) begin
      push_cmd.info[0] = node_id;
      push_cmd.info[1] = mode;
      push_cmd.info[2] = tally;
    end else begin
      push_cmd.info[0] = err_code;
    end
  end

  assign push_valid = pend && !act_mode;
  assign done       = pend && (act_mode || push_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      len      <= '0;
      xacc     <= '0;
      pend     <= 1'b0;
      pend_bad <= 1'b0;
      mode     <= 8'd1;
      tally    <= '0;
      for (int i = 0; i < WIN; i++) begin
        store[i] <= '0;
      end
    end else begin
      if (done) begin
        pend <= 1'b0;
        if (act_mode && dlc != 8'd0) begin
          mode <= store[4];
        end
        if (is_err) begin
          tally <= tally + 8'd1;
        end
      end
      if (accept) begin
        if (count == '0) begin
          if (rx_byte == SYNC_BYTE) begin
            count <= CNT_W'(1);
          end
        end else if (count == CNT_W'(1)) begin
          len  <= rx_byte;
          xacc <= '0;
          if ({1'b0, rx_byte} > MAX_LEN) begin
            count <= '0;
          end else begin
            count <= CNT_W'(2);
          end
        end else begin
          if (offset < CNT_W'(WIN)) begin
            store[offset[IDX_W-1:0]] <= rx_byte;
          end
          if (9'(count) == tail_pos) begin
            count <= '0;
            if (rx_byte == TAIL_BYTE) begin
              pend     <= 1'b1;
              pend_bad <= (xacc != 8'd0);
            end
          end else begin
            xacc  <= xacc ^ rx_byte;
            count <= count + CNT_W'(1);
          end
        end
      end
    end
  end

endmodule

### rtl/sfcg_cmd_fifo.sv
// Short command queue between the frame parser and the reply engine.
module sfcg_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  sfcg_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output sfcg_pkg::cmd_t rd_cmd
);
  import sfcg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (fill != CNT_W'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_cmd   = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/sfcg_back.sv
// Reply engine: turns queued commands into CAN requests or serialized reply frames.
module sfcg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  sfcg_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           kind,
  output logic [7:0]     tx_byte,
  output logic           last,
  output logic [15:0]    frame_id,
  output logic [3:0]     frame_dlc,
  output logic [63:0]    frame_data
);
  import sfcg_pkg::*;

  cmd_t       cur;
  logic       busy;
  logic [3:0] idx;

  logic       slot_free;
  logic [3:0] n;
  logic [7:0] op;
  logic [7:0] chk;
  logic [1:0] info_idx;
  logic [3:0] final_idx;
  logic [7:0] byte_val;
  logic       at_end;

  assign cmd_ready = !busy;
  assign slot_free = !out_valid || out_ready;
  assign n         = cur.is_status ? 4'd4 : 4'd1;
  assign op        = cur.is_status ? OP_STATUS : OP_ERROR;
  assign chk       = op ^ {4'd0, n} ^ cur.info[0] ^ cur.info[1] ^ cur.info[2] ^ cur.info[3];
  assign info_idx  = idx[1:0] - 2'd2;
  assign final_idx = n + 4'd7;
  assign at_end    = cur.is_can || (idx == final_idx);

  always_comb begin
    if (idx == 4'd0) begin
      byte_val = SYNC_BYTE;
    end else if (idx == 4'd1) begin
      byte_val = {4'd0, n} + 8'd4;
    end else if (idx == 4'd2) begin
      byte_val = op;
    end else if (idx == 4'd3 || idx == 4'd4) begin
      byte_val = 8'd0;
    end else if (idx == 4'd5) begin
      byte_val = {4'd0, n};
    end else if (idx < n + 4'd6) begin
      byte_val = cur.info[info_idx];
    end else if (idx == n + 4'd6) begin
      byte_val = chk;
    end else begin
      byte_val = TAIL_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (!busy) begin
        if (cmd_valid) begin
          cur  <= cmd;
          busy <= 1'b1;
          idx  <= '0;
        end
      end
      if (busy && slot_free) begin
        out_valid <= 1'b1;
        last      <= at_end;
        idx       <= idx + 4'd1;
        if (at_end) begin
          busy <= 1'b0;
        end
        if (cur.is_can) begin
          kind       <= 1'b1;
          tx_byte    <= 8'd0;
          frame_id   <= cur.id;
          frame_dlc  <= cur.dlc;
          frame_data <= cur.data;
        end else begin
          kind       <= 1'b0;
          tx_byte    <= byte_val;
          frame_id   <= '0;
          frame_dlc  <= '0;
          frame_data <= '0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/serial_frame_command_gateway.sv
// Top level of the serial frame command gateway: parser, command queue and reply engine.
//
//   Channel   Signals                                   Beat
//   input     in_valid, in_ready, rx_byte               one received serial byte
//   output    out_valid, out_ready, kind, tx_byte,      one reply byte or one CAN request
//             last, frame_id, frame_dlc, frame_data
//   config    cfg_wr_en, cfg_wr_data                    node identifier write
//
// The parser takes one byte per cycle while not stalled; after a correct end byte, input
// stalls while the frame is decoded, and it stalls longer if the queue is full.
// The reply engine takes a command when idle, then sends one beat per cycle unless out_ready holds it back:
// a CAN request is one beat, an error frame nine and a status reply twelve.
// Reset is synchronous: the frame buffer clears, the mode reads 1 and the error count 0.
// The command queue lets the parser keep taking bytes while a result waits downstream.
module serial_frame_command_gateway #(
  parameter int BUFFER_BYTES = sfcg_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_DLC      = sfcg_pkg::MAX_DLC_DEF,
  parameter int QUEUE_DEPTH  = sfcg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [15:0] frame_id,
  output logic [3:0]  frame_dlc,
  output logic [63:0] frame_data
);
  import sfcg_pkg::*;

  logic [7:0] node_id;
  logic       push_valid;
  logic       push_ready;
  cmd_t       push_cmd;
  logic       pop_valid;
  logic       pop_ready;
  cmd_t       pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= '0;
    end else if (cfg_wr_en) begin
      node_id <= cfg_wr_data;
    end
  end

  sfcg_front #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_DLC      (MAX_DLC)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .node_id    (node_id),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  sfcg_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_cmd   (push_cmd),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_cmd   (pop_cmd)
  );

  sfcg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (pop_valid),
    .cmd_ready  (pop_ready),
    .cmd        (pop_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .tx_byte    (tx_byte),
    .last       (last),
    .frame_id   (frame_id),
    .frame_dlc  (frame_dlc),
    .frame_data (frame_data)
  );

endmodule
